>>> sv/rpc_pkg.sv
// Shared types and constants for the RC PWM capture and calibrate unit.
package rpc_pkg;

   localparam int NUM_PINS    = 4;
   localparam int NUM_FUNCS   = 4;
   localparam int NUM_CALS    = 4;
   localparam int TIME_W      = 32;
   localparam int WIDTH_W     = 16;
   localparam int VALUE_W     = 11;
   localparam int CAL_W       = 48;
   localparam int MAP_W       = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int NUM_W       = 25;
   localparam int QUO_W       = 9;
   localparam int QUEUE_DEPTH = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN1_CAL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAN4_CAL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FUNCTION_MAP = 3'd4;

   localparam logic [CAL_W-1:0]   CAL_RESET  = 48'd8590032897000;
   localparam logic [MAP_W-1:0]   MAP_RESET  = 12'd1672;
   localparam logic [VALUE_W-1:0] CENTER_OUT = 11'd1500;
   localparam logic [QUO_W-1:0]   HALF_RANGE = 9'd500;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 16'hFFFF;

   typedef logic [WIDTH_W-1:0] width_type;
   typedef width_type [NUM_PINS-1:0] width_set_type;
   typedef logic [VALUE_W-1:0] value_type;

   // Front end to queue
   typedef struct packed {
      logic          valid;
      width_set_type widths;
   } q_push_type;

   // Queue to back end
   typedef struct packed {
      logic          valid;
      width_set_type widths;
   } q_pop_type;

endpackage

>>> sv/rpc_if.sv
// Channel interfaces: sample requests and calibrated responses.
interface rpc_req_if;
   logic                             valid;
   logic                             ready;
   logic [rpc_pkg::NUM_PINS-1:0]     pin_levels;
   logic [rpc_pkg::TIME_W-1:0]       time_us;

   modport source (output valid, output pin_levels, output time_us, input ready);
   modport sink (input valid, input pin_levels, input time_us, output ready);
endinterface

interface rpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rpc_pkg::VALUE_W-1:0]   roll_value;
   logic [rpc_pkg::VALUE_W-1:0]   pitch_value;
   logic [rpc_pkg::VALUE_W-1:0]   throttle_value;
   logic [rpc_pkg::VALUE_W-1:0]   yaw_value;

   modport source (output valid, output roll_value, output pitch_value,
                   output throttle_value, output yaw_value, input ready);
   modport sink (input valid, input roll_value, input pitch_value,
                 input throttle_value, input yaw_value, output ready);
endinterface

>>> sv/rpc_front.sv
// Front end: pin edge detection, pulse width capture and queue push.
module rpc_front #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                clock,
   input  logic                reset,
   rpc_req_if.sink             req_chan,
   input  logic                q_full,
   output rpc_pkg::q_push_type push
);
   import rpc_pkg::*;

   localparam int LIVE = (NUM_CHANNELS < NUM_PINS) ? NUM_CHANNELS : NUM_PINS;

   logic [LIVE-1:0]             prev_ff, prev_in;
   logic [LIVE-1:0][TIME_W-1:0] rise_ff, rise_in;
   width_type [LIVE-1:0]        width_ff, width_in;
   logic                        accept;
   width_set_type               snap;

   // Take a sample whenever the queue has room
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   // Per channel edge handling
   for (genvar g = 0; g < LIVE; g++) begin : g_chan
      logic [TIME_W-1:0] elapsed;
      logic              lvl;

      assign elapsed = req_chan.time_us - rise_ff[g];
      assign lvl     = req_chan.pin_levels[g];

      always_comb begin
         prev_in[g]  = prev_ff[g];
         rise_in[g]  = rise_ff[g];
         width_in[g] = width_ff[g];
         if (accept) begin
            if (lvl && !prev_ff[g]) begin
               prev_in[g] = 1'b1;
               rise_in[g] = req_chan.time_us;
            end else if (!lvl && prev_ff[g]) begin
               prev_in[g]  = 1'b0;
               width_in[g] = (elapsed > TIME_W'(WIDTH_MAX)) ? WIDTH_MAX
                                                             : elapsed[WIDTH_W-1:0];
            end
         end
      end
   end

   // Channels that are not built read as zero width
   always_comb begin
      snap            = '0;
      snap[LIVE-1:0]  = width_in;
   end

   assign push.valid  = accept;
   assign push.widths = snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         rise_ff  <= '0;
         width_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         rise_ff  <= rise_in;
         width_ff <= width_in;
      end
   end

endmodule

>>> sv/rpc_queue.sv
// Two-entry queue of captured width sets between front and back end.
module rpc_queue (
   input  logic                clock,
   input  logic                reset,
   input  rpc_pkg::q_push_type push,
   output logic                q_full,
   output rpc_pkg::q_pop_type  pop,
   input  logic                pop_ready
);
   import rpc_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   width_set_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign q_full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.widths = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !q_full;
   assign do_pop     = pop.valid && pop_ready;

   // Advance pointers and level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.widths;
      end
   end

endmodule

>>> sv/rpc_back.sv
// Back end: calibration registers, function mapping and shared scaling divider.
module rpc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rpc_pkg::CAL_W-1:0]           csr_wdata,
   input  rpc_pkg::q_pop_type                  pop,
   output logic                                pop_ready,
   rpc_rsp_if.source                           rsp_chan
);
   import rpc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_PUSH} state_type;

   localparam int STEPS    = 3;
   localparam int FN_W     = $clog2(NUM_FUNCS);
   localparam int STEP_W   = $clog2(STEPS);
   localparam int CH_W     = $clog2(NUM_CALS);

   logic [CAL_W-1:0]            cal_ff [NUM_CALS];
   logic [MAP_W-1:0]            map_ff;

   state_type                   state_ff, state_in;
   logic [FN_W-1:0]             fn_ff, fn_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   width_set_type               widths_ff, widths_in;
   logic [NUM_W-1:0]            num_ff, num_in;
   logic [NUM_W-1:0]            dsh_ff, dsh_in;
   logic [QUO_W-1:0]            quo_ff, quo_in;
   logic                        below_ff, below_in;
   logic                        rev_ff, rev_in;
   value_type [NUM_FUNCS-1:0]   res_ff, res_in;
   value_type [NUM_FUNCS-1:0]   out_ff, out_in;
   logic                        out_valid_ff, out_valid_in;

   logic [2:0]                  sel;
   logic [CH_W-1:0]             ch;
   logic                        rev;
   logic [CAL_W-1:0]            cal;
   width_type                   actual, lo, ctr, hi, clamped, delta, span;
   logic                        below, full;
   logic [NUM_W-1:0]            rem, trial;
   logic [QUO_W-1:0]            quo;
   logic                        last_fn;

   // Centre plus or minus the offset, offset capped at half range
   function automatic value_type compose(input logic dn, input logic [QUO_W-1:0] diff);
      logic [QUO_W-1:0] d;
      d = (diff > HALF_RANGE) ? HALF_RANGE : diff;
      return dn ? CENTER_OUT - VALUE_W'(d) : CENTER_OUT + VALUE_W'(d);
   endfunction

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CALS; i++) begin
            cal_ff[i] <= CAL_RESET;
         end
         map_ff <= MAP_RESET;
      end else if (csr_wr_en) begin
         if (csr_index <= CSR_CHAN4_CAL) begin
            cal_ff[CH_W'(csr_index - CSR_CHAN1_CAL)] <= csr_wdata;
         end else if (csr_index == CSR_FUNCTION_MAP) begin
            map_ff <= csr_wdata[MAP_W-1:0];
         end
      end
   end

   // Select channel and calibration for the current function
   always_comb begin
      sel    = map_ff[3 * int'(fn_ff) +: 3];
      ch     = sel[CH_W-1:0];
      rev    = sel[2];
      actual = widths_ff[ch];
      cal    = cal_ff[ch];
      lo     = cal[15:0];
      ctr    = cal[31:16];
      hi     = cal[47:32];
      below  = actual < ctr;
      if (below) begin
         clamped = (actual < lo) ? lo : actual;
         full    = lo >= ctr;
         delta   = ctr - clamped;
         span    = ctr - lo;
      end else begin
         clamped = (actual > hi) ? hi : actual;
         full    = hi <= ctr;
         delta   = clamped - ctr;
         span    = hi - ctr;
      end
   end

   // Three restoring division steps per cycle
   always_comb begin
      rem = num_ff;
      quo = quo_ff;
      for (int j = 0; j < STEPS; j++) begin
         trial = dsh_ff >> j;
         if (rem >= trial) begin
            rem = rem - trial;
            quo = {quo[QUO_W-2:0], 1'b1};
         end else begin
            quo = {quo[QUO_W-2:0], 1'b0};
         end
      end
   end

   assign last_fn = (fn_ff == FN_W'(NUM_FUNCS - 1));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fn_in        = fn_ff;
      step_in      = step_ff;
      widths_in    = widths_ff;
      num_in       = num_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      below_in     = below_ff;
      rev_in       = rev_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      pop_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            pop_ready = 1'b1;
            if (pop.valid) begin
               widths_in = pop.widths;
               fn_in     = '0;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            if (actual == ctr || full) begin
               res_in[fn_ff] = (actual == ctr) ? CENTER_OUT
                                               : compose(below != rev, HALF_RANGE);
               fn_in    = fn_ff + 1'b1;
               state_in = last_fn ? S_PUSH : S_PREP;
            end else begin
               num_in   = NUM_W'(delta) * NUM_W'(HALF_RANGE);
               dsh_in   = {1'b0, span, 8'd0};
               quo_in   = '0;
               step_in  = '0;
               below_in = below;
               rev_in   = rev;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            num_in  = rem;
            dsh_in  = dsh_ff >> STEPS;
            quo_in  = quo;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               res_in[fn_ff] = compose(below_ff != rev_ff, quo);
               fn_in         = fn_ff + 1'b1;
               state_in      = last_fn ? S_PUSH : S_PREP;
            end
         end
         S_PUSH: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         fn_ff        <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         fn_ff        <= fn_in;
         step_ff      <= step_in;
      end
      widths_ff <= widths_in;
      num_ff    <= num_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      below_ff  <= below_in;
      rev_ff    <= rev_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.roll_value     = out_ff[0];
   assign rsp_chan.pitch_value    = out_ff[1];
   assign rsp_chan.throttle_value = out_ff[2];
   assign rsp_chan.yaw_value      = out_ff[3];

endmodule

>>> sv/rc_pwm_capture_and_calibrate_unit.sv
// RC PWM capture and calibrate unit: top level.
// Flow: the back end's shared divider takes one sample at a time while the queue holds more:
//   it loads the sample, settles each function in the prep state in the centre or full-offset
//   cases, runs each function that needs scaling through the division state, then hands
//   over the response, waiting while the receiver is not ready.
// Reset: synchronous, clears captured widths and queue, loads default calibration.
module rc_pwm_capture_and_calibrate_unit #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   rpc_req_if.sink                         req_chan,
   rpc_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [rpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpc_pkg::CAL_W-1:0]       csr_wdata
);
   import rpc_pkg::*;

   q_push_type push;
   q_pop_type  pop;
   logic       q_full;
   logic       pop_ready;

   rpc_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   rpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .q_full    (q_full),
      .pop       (pop),
      .pop_ready (pop_ready)
   );

   rpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the RC PWM capture and calibrate unit: pulse trains checked against a predictor.
module tb_top;
   import rpc_pkg::*;

   localparam int ITEMS_PER_PHASE = 130;
   localparam int NUM_PHASES      = 9;
   localparam int DRAIN_CYCLES    = 30;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_REPORTS     = 10;
   localparam int MAX_GAP         = 11;
   localparam int NUM_DIRECTED    = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX = '1;

   typedef value_type [NUM_FUNCS-1:0] fn_values_type;
   typedef enum int {CAL_TYPICAL, CAL_FLAT, CAL_INVERTED, CAL_RANDOM, CAL_WIDE} cal_style_type;

   // Predicts the four function values from captured widths and holds them until checked
   class pulse_scoreboard;
      logic [CAL_W-1:0]  chan_cal [NUM_CALS];
      logic [MAP_W-1:0]  func_map;
      bit [NUM_PINS-1:0] was_high;
      logic [TIME_W-1:0] rise_at [NUM_PINS];
      width_type         captured [NUM_PINS];
      fn_values_type     expected_q [$];
      int                bad_results;
      string             fn_names [NUM_FUNCS];

      function new();
         foreach (chan_cal[i]) chan_cal[i] = CAL_RESET;
         func_map = MAP_RESET;
         was_high = '0;
         foreach (rise_at[i]) rise_at[i] = '0;
         foreach (captured[i]) captured[i] = '0;
         bad_results = 0;
         fn_names = '{"roll", "pitch", "throttle", "yaw"};
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
         if (idx < NUM_CALS)
            chan_cal[idx] = data;
         else if (idx == CSR_FUNCTION_MAP)
            func_map = data[MAP_W-1:0];
      endfunction

      // Clamp to the window, then scale the distance from centre onto +/- 500
      function value_type scaled(width_type w, width_type lo, width_type ctr, width_type hi,
                                 bit rev);
         int unsigned pos, offset, half;
         bit below;
         half = 32'(HALF_RANGE);
         if (w == ctr) return CENTER_OUT;
         pos = 32'(w);
         below = (w < ctr);
         if (below) begin
            if (pos < lo) pos = 32'(lo);
            if (lo >= ctr) offset = half;
            else offset = ((ctr - pos) * half) / (ctr - lo);
         end else begin
            if (pos > hi) pos = 32'(hi);
            if (hi <= ctr) offset = half;
            else offset = ((pos - ctr) * half) / (hi - ctr);
         end
         if (offset > half) offset = half;
         if (below != rev) return CENTER_OUT - value_type'(offset);
         return CENTER_OUT + value_type'(offset);
      endfunction

      // Update edge capture, then queue the expected response
      function void note_sample(logic [NUM_PINS-1:0] pins, logic [TIME_W-1:0] stamp);
         logic [TIME_W-1:0] elapsed;
         logic [2:0]        sel;
         logic [CAL_W-1:0]  c;
         fn_values_type     vals;
         for (int i = 0; i < NUM_PINS; i++) begin
            if (pins[i]) begin
               if (!was_high[i]) begin
                  was_high[i] = 1'b1;
                  rise_at[i] = stamp;
               end
            end else if (was_high[i]) begin
               elapsed = stamp - rise_at[i];
               was_high[i] = 1'b0;
               captured[i] = (elapsed > TIME_W'(WIDTH_MAX)) ? WIDTH_MAX : elapsed[WIDTH_W-1:0];
            end
         end
         for (int f = 0; f < NUM_FUNCS; f++) begin
            sel = func_map[3*f +: 3];
            c = chan_cal[sel[1:0]];
            vals[f] = scaled(captured[sel[1:0]], c[15:0], c[31:16], c[47:32], sel[2]);
         end
         expected_q.push_back(vals);
      endfunction

      function void check_result(fn_values_type got);
         fn_values_type want;
         bit wrong;
         if (expected_q.size() == 0) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
               $display("unexpected response: roll %0d pitch %0d throttle %0d yaw %0d",
                        got[0], got[1], got[2], got[3]);
            return;
         end
         want = expected_q.pop_front();
         wrong = 1'b0;
         for (int f = 0; f < NUM_FUNCS; f++)
            if (got[f] !== want[f]) wrong = 1'b1;
         if (!wrong) return;
         bad_results++;
         if (bad_results <= MAX_REPORTS)
            for (int f = 0; f < NUM_FUNCS; f++)
               if (got[f] !== want[f])
                  $display("mismatch on %s: expected %0d, got %0d",
                           fn_names[f], want[f], got[f]);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int failures();
         return bad_results + expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAL_W-1:0]     csr_wdata;

   rpc_req_if req_chan ();
   rpc_rsp_if rsp_chan ();

   pulse_scoreboard   sb;
   bit                no_idle;
   int                hold_len;
   logic [NUM_PINS-1:0] pin_state;
   logic [TIME_W-1:0]   now_us;
   logic [TIME_W-1:0]   fall_at [NUM_PINS];

   rc_pwm_capture_and_calibrate_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Pick a pulse width for a channel, mostly around its calibration window
   function automatic int unsigned target_width(int ch);
      logic [CAL_W-1:0] c;
      int unsigned lo, ctr, hi, wmin, wmax;
      c = sb.chan_cal[ch];
      lo = 32'(c[15:0]);
      ctr = 32'(c[31:16]);
      hi = 32'(c[47:32]);
      wmin = lo;
      if (ctr < wmin) wmin = ctr;
      if (hi < wmin) wmin = hi;
      wmax = lo;
      if (ctr > wmax) wmax = ctr;
      if (hi > wmax) wmax = hi;
      case ($urandom_range(0, 9))
         0: return ctr;
         1: return lo;
         2: return hi;
         3: return $urandom_range(0, 65535);
         4: return $urandom_range(65536, 200000);
         default: return $urandom_range((wmin > 300) ? wmin - 300 : 0, wmax + 300);
      endcase
   endfunction

   function automatic logic [CAL_W-1:0] make_cal(cal_style_type style);
      int unsigned lo, ctr, hi;
      logic [CAL_W-1:0] raw;
      case (style)
         CAL_TYPICAL: begin
            lo = $urandom_range(700, 1300);
            ctr = lo + $urandom_range(1, 600);
            hi = ctr + $urandom_range(1, 700);
         end
         CAL_FLAT: begin
            lo = $urandom_range(0, 65535);
            ctr = lo;
            hi = lo;
         end
         CAL_INVERTED: begin
            ctr = $urandom_range(1000, 2000);
            lo = ctr + $urandom_range(0, 300);
            hi = ctr - $urandom_range(0, 300);
         end
         CAL_WIDE: begin
            lo = $urandom_range(0, 100);
            ctr = $urandom_range(20000, 40000);
            hi = $urandom_range(60000, 65535);
         end
         default: begin
            raw = CAL_W'({$urandom(), $urandom()});
            return raw;
         end
      endcase
      return {hi[15:0], ctr[15:0], lo[15:0]};
   endfunction

   // Advance the pulse trains: mostly land exactly on a planned falling edge
   task automatic next_pulse_sample(output logic [NUM_PINS-1:0] pins,
                                    output logic [TIME_W-1:0] stamp);
      int unsigned advance;
      int gap_to_fall, nearest;
      nearest = -1;
      if ($urandom_range(0, 19) == 0) begin
         // noise: jump anywhere in time with arbitrary levels
         now_us = $urandom();
         pins = NUM_PINS'($urandom_range(0, 15));
         for (int i = 0; i < NUM_PINS; i++)
            if (pins[i] && !pin_state[i]) fall_at[i] = now_us + target_width(i);
         pin_state = pins;
      end else begin
         for (int i = 0; i < NUM_PINS; i++)
            if (pin_state[i]) begin
               gap_to_fall = $signed(fall_at[i] - now_us);
               if (gap_to_fall < 0) gap_to_fall = 0;
               if (nearest < 0 || gap_to_fall < nearest) nearest = gap_to_fall;
            end
         if (nearest >= 0 && $urandom_range(0, 3) != 0)
            advance = nearest;
         else
            advance = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30000 : 400);
         now_us = now_us + advance;
         for (int i = 0; i < NUM_PINS; i++)
            if (pin_state[i]) begin
               if ($signed(now_us - fall_at[i]) >= 0) pin_state[i] = 1'b0;
            end else if ($urandom_range(0, 2) == 0) begin
               pin_state[i] = 1'b1;
               fall_at[i] = now_us + target_width(i);
            end
         pins = pin_state;
      end
      stamp = now_us;
   endtask

   // Offer one sample and return at the edge of its transfer
   task automatic send_sample(logic [NUM_PINS-1:0] pins, logic [TIME_W-1:0] stamp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.pin_levels <= pins;
      req_chan.time_us    <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_sample(pins, stamp);
   endtask

   // Drop valid and wait until every response is back
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CAL_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
   endtask

   // Phase 1 all zero, phase 2 all ones, last phase back to defaults, random between
   task automatic configure(int phase);
      logic [CAL_W-1:0] data;
      logic [MAP_W-1:0] map_bits;
      for (int ch = 0; ch < NUM_CALS; ch++) begin
         if (phase == 1) data = '0;
         else if (phase == 2) data = '1;
         else if (phase == NUM_PHASES) data = CAL_RESET;
         else data = make_cal(cal_style_type'($urandom_range(0, 4)));
         csr_write(CSR_CHAN1_CAL + CSR_IDX_W'(ch), data);
      end
      if (phase == 1) map_bits = '0;
      else if (phase == 2) map_bits = '1;
      else if (phase == NUM_PHASES) map_bits = MAP_RESET;
      else map_bits = MAP_W'($urandom_range(0, 4095));
      data = CAL_W'({$urandom(), $urandom()});
      data[MAP_W-1:0] = map_bits;
      csr_write(CSR_FUNCTION_MAP, data);
      // an index past the last register must be ignored
      csr_write(CSR_IDX_W'($urandom_range(CSR_FUNCTION_MAP + 1, CSR_LAST_INDEX)),
                CAL_W'({$urandom(), $urandom()}));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      fn_values_type got;
      rsp_chan.ready = 1'b0;
      do @(negedge clock); while (reset !== 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_len > 0) begin
            stall = hold_len;
            hold_len = 0;
         end
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         got = {rsp_chan.yaw_value, rsp_chan.throttle_value,
                rsp_chan.pitch_value, rsp_chan.roll_value};
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [NUM_PINS-1:0] pins;
      logic [TIME_W-1:0]   stamp;
      logic [NUM_PINS-1:0] dir_pins [NUM_DIRECTED];
      logic [TIME_W-1:0]   dir_time [NUM_DIRECTED];

      // Defaults: low, centre, high, above high, zero width, below low, timestamp wrap,
      // saturation, time running backwards, level held, alternating bits, exact centre on wrap
      dir_pins = '{4'h0, 4'hF, 4'hE, 4'hC, 4'h8, 4'h0, 4'h1, 4'h0, 4'h2, 4'h0, 4'h4, 4'h0,
                   4'h8, 4'h0, 4'h1, 4'h0, 4'hF, 4'hF, 4'h5, 4'hA, 4'h0, 4'hF, 4'h0};
      dir_time = '{32'h0, 32'd100, 32'd1100, 32'd1600, 32'd2100, 32'd2600, 32'd3000,
                   32'd3000, 32'd4000, 32'd4700, 32'hFFFF_FF00, 32'h0000_0500,
                   32'h0000_1000, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0010, 32'h0000_0020, 32'h0000_04F0, 32'h5555_5555,
                   32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_05DB};

      sb = new();
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.pin_levels = '0;
      req_chan.time_us = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_idle = 1'b0;
      hold_len = 0;
      pin_state = '0;
      now_us = '0;
      foreach (fall_at[i]) fall_at[i] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_DIRECTED; k++)
         send_sample(dir_pins[k], dir_time[k]);

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         drain_results();
         configure(phase);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while samples keep coming, so the input backs up
            if (phase == 3 && n == 10) hold_len = HOLD_CYCLES;
            if (n == 70) drain_results();
            next_pulse_sample(pins, stamp);
            send_sample(pins, stamp);
         end
      end
      drain_results();

      if (sb.failures() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> rc_pwm_capture_and_calibrate_unit.f
sv/rpc_pkg.sv
sv/rpc_if.sv
sv/rpc_front.sv
sv/rpc_queue.sv
sv/rpc_back.sv
sv/rc_pwm_capture_and_calibrate_unit.sv
dv/tb_top.sv
